// ===== design/reliable_datagram_receiver_assert.svh =====
// assertion macros for the datagram receiver rtl
// depends on nothing; files that check their own logic include this header
`ifndef RELIABLE_DATAGRAM_RECEIVER_ASSERT_SVH
`define RELIABLE_DATAGRAM_RECEIVER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define RDR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RDR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rdr_pkg.sv =====
// shared types, codes and constants of the datagram receiver
// no dependencies; imported by every module of the block but the ram
package rdr_pkg;

   localparam int SEQ_W   = 32;
   localparam int SIG_W   = 32;
   localparam int LEN_W   = 11;
   localparam int TYPE_W  = 3;
   localparam int WIN_W   = 16;
   localparam int RETRY_W = 4;
   localparam int KIND_W  = 2;
   localparam int ENTRY_W = SEQ_W + SIG_W + TYPE_W + LEN_W;

   // largest payload length honored, longer ones saturate
   localparam logic [LEN_W-1:0] MAX_PAYLOAD = 11'd1024;

   // register reset values
   localparam logic [WIN_W-1:0]   WINDOW_RESET  = 16'd2048;
   localparam logic [RETRY_W-1:0] RETRIES_RESET = 4'd3;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_WINDOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_RETRIES = 1'b1;

   // item operation codes
   localparam logic OP_PACKET  = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   // packet type codes
   localparam logic [TYPE_W-1:0] TYPE_DAT = 3'd0;
   localparam logic [TYPE_W-1:0] TYPE_ACK = 3'd1;
   localparam logic [TYPE_W-1:0] TYPE_SYN = 3'd2;
   localparam logic [TYPE_W-1:0] TYPE_FIN = 3'd3;
   localparam logic [TYPE_W-1:0] TYPE_RST = 3'd4;

   // reply kind codes
   localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RST    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GIVEUP = 2'd2;

   // connection phase
   typedef enum logic [3:0] {
      PH_HANDSHAKE = 4'b0001,
      PH_ESTAB     = 4'b0010,
      PH_DATA      = 4'b0100,
      PH_CLOSED    = 4'b1000
   } phase_type;

   // one input item after unpacking
   typedef struct packed {
      logic              op;
      logic [TYPE_W-1:0] ptype;
      logic [SEQ_W-1:0]  seq;
      logic [LEN_W-1:0]  len;
      logic [SIG_W-1:0]  sig;
   } item_type;

   // one reply item
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SEQ_W-1:0]  ack;
      logic [WIN_W-1:0]  win;
      logic [LEN_W-1:0]  pay;
      logic              dup;
      logic              rel;
      logic              last;
   } reply_type;

   // replies handed from the controller to the output queue
   typedef struct packed {
      logic      push;
      logic      two;
      reply_type first;
      reply_type second;
   } reply_push_type;

   function automatic reply_type make_reply(
      input logic [KIND_W-1:0] kind,
      input logic [SEQ_W-1:0]  ack,
      input logic [WIN_W-1:0]  win,
      input logic [LEN_W-1:0]  pay,
      input logic              dup,
      input logic              rel
   );
      reply_type r;
      r.kind = kind;
      r.ack  = ack;
      r.win  = win;
      r.pay  = pay;
      r.dup  = dup;
      r.rel  = rel;
      r.last = 1'b0;
      return r;
   endfunction

   // window minus payload, floored at zero
   function automatic logic [WIN_W-1:0] shrink_window(
      input logic [WIN_W-1:0] win,
      input logic [LEN_W-1:0] len
   );
      logic [WIN_W-1:0] len_w;
      len_w = {{(WIN_W-LEN_W){1'b0}}, len};
      return (win > len_w) ? (win - len_w) : '0;
   endfunction

endpackage

// ===== design/reliable_datagram_receiver.sv =====
// A packet is searched against the stored entries (at most TABLE_DEPTH), one table read
// per cycle, then decided. A timeout goes to the decision directly, or first fetches the
// last stored entry when established with a non-empty table. A second reply is queued
// behind the first. One item in work at a time; a decision also waits until earlier
// replies leave. Reset is synchronous and active high; it clears control state, the entry
// count and the queue valids and reloads the configuration registers, not the table.
module reliable_datagram_receiver
   import rdr_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [79:0]          req_tdata,  // seq_num, payload_len, content_sig, zero pad
   input  logic [3:0]           req_tuser,  // operation, pkt_type
   // result items
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,  // ack_num, adv_window, payload_echo, zero pad
   output logic [3:0]           rsp_tuser,  // reply_kind, was_duplicate, released
   output logic                 rsp_tlast,
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WIN_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [WIN_W-1:0]   window_size_ff;
   logic [RETRY_W-1:0] max_retries_ff;
   item_type           req_item;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               q_empty;
   reply_push_type     push;
   reply_type          rsp_reply;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_RESET;
         max_retries_ff <= RETRIES_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IDX_WINDOW:  window_size_ff <= csr_wdata;
            CSR_IDX_RETRIES: max_retries_ff <= csr_wdata[RETRY_W-1:0];
            default:         window_size_ff <= window_size_ff;
         endcase
      end
   end

   // unpack the input item
   always_comb begin
      req_item.op    = req_tuser[0];
      req_item.ptype = req_tuser[3:1];
      req_item.seq   = req_tdata[31:0];
      req_item.len   = req_tdata[42:32];
      req_item.sig   = req_tdata[74:43];
   end

   // seen table: sequence, signature, type and length per entry
   rdr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rdr_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_item    (req_item),
      .window_size (window_size_ff),
      .max_retries (max_retries_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .q_empty     (q_empty),
      .push        (push)
   );

   rdr_reply_q u_reply_q (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .empty      (q_empty),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_reply  (rsp_reply)
   );

   // pack the result item
   assign rsp_tdata = {5'b0, rsp_reply.pay, rsp_reply.win, rsp_reply.ack};
   assign rsp_tuser = {rsp_reply.rel, rsp_reply.dup, rsp_reply.kind};
   assign rsp_tlast = rsp_reply.last;

endmodule

// ===== design/rdr_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// depends on nothing
module rdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rdr_reply_q.sv =====
// two-entry reply queue feeding the result channel
// depends on rdr_pkg for the reply types
module rdr_reply_q
   import rdr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  reply_push_type push,
   output logic           empty,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output reply_type      rsp_reply
);

   logic      head_valid_ff, head_valid_in;
   logic      tail_valid_ff, tail_valid_in;
   reply_type head_ff, head_in;
   reply_type tail_ff, tail_in;
   logic      pop;

   assign pop        = head_valid_ff & rsp_tready;
   assign empty      = ~head_valid_ff & ~tail_valid_ff;
   assign rsp_tvalid = head_valid_ff;
   assign rsp_reply  = head_ff;

   // load both slots on push, shift tail to head on each taken item
   always_comb begin
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      if (push.push) begin
         head_valid_in = 1'b1;
         tail_valid_in = push.two;
         head_in       = push.first;
         tail_in       = push.second;
      end else if (pop) begin
         head_valid_in = tail_valid_ff;
         tail_valid_in = 1'b0;
         head_in       = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ===== design/rdr_ctrl.sv =====
// item sequencer: duplicate search over the seen table, protocol decision
// depends on rdr_pkg and the assertion header; drives the table ram and reply queue
`include "reliable_datagram_receiver_assert.svh"

module rdr_ctrl
   import rdr_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   localparam int AW = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  item_type           req_item,
   input  logic [WIN_W-1:0]   window_size,
   input  logic [RETRY_W-1:0] max_retries,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [ENTRY_W-1:0] wr_data,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   input  logic [ENTRY_W-1:0] rd_data,
   input  logic               q_empty,
   output reply_push_type     push
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_FETCH  = 4'b0100,
      ST_DECIDE = 4'b1000
   } ctrl_state_type;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   ctrl_state_type     state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [RETRY_W-1:0] retry_ff, retry_in;
   logic [LEN_W-1:0]   last_len_ff, last_len_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic               hit_ff, hit_in;
   item_type           item_ff, item_in;

   logic               accept;
   logic               decide;
   logic [LEN_W-1:0]   len_sat;
   logic [ENTRY_W-1:0] entry_key;
   logic               match;
   logic [CNT_W-1:0]   last_idx;
   logic [SEQ_W-1:0]   rd_seq;
   logic [LEN_W-1:0]   rd_len;
   logic [SEQ_W-1:0]   tail_seq;
   logic [LEN_W-1:0]   tail_len;
   logic [RETRY_W-1:0] retry_next;
   logic [SEQ_W-1:0]   seq_plus_one;
   reply_type          r0, r1;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign decide     = (state_ff == ST_DECIDE) & q_empty;

   // saturate the payload length before it is stored or compared
   assign len_sat = (req_item.len > MAX_PAYLOAD) ? MAX_PAYLOAD : req_item.len;

   // table entry: sequence, signature, type, length
   assign entry_key = {item_ff.seq, item_ff.sig, item_ff.ptype, item_ff.len};
   assign match     = pend_ff & (rd_data == entry_key);
   assign rd_seq    = rd_data[ENTRY_W-1 -: SEQ_W];
   assign rd_len    = rd_data[LEN_W-1:0];
   assign last_idx  = count_ff - CNT_W'(1);

   // last stored entry, or zero for an empty table
   assign tail_seq = (count_ff != '0) ? rd_seq : '0;
   assign tail_len = (count_ff != '0) ? rd_len : '0;

   assign retry_next   = retry_ff + RETRY_W'(1);
   assign seq_plus_one = item_ff.seq + SEQ_W'(1);

   // table reads: one entry per cycle while searching, last entry on fetch
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = last_idx[AW-1:0];
      case (state_ff)
         ST_SEARCH: begin
            rd_en   = (idx_ff < count_ff) & ~match;
            rd_addr = idx_ff[AW-1:0];
         end
         ST_FETCH: begin
            rd_en = 1'b1;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // sequencer and protocol decision
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      retry_in    = retry_ff;
      last_len_in = last_len_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      hit_in      = hit_ff;
      item_in     = item_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[AW-1:0];
      wr_data     = entry_key;
      r0          = '0;
      r1          = '0;
      push        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in     = req_item;
               item_in.len = len_sat;
               idx_in      = '0;
               pend_in     = 1'b0;
               hit_in      = 1'b0;
               if (phase_ff == PH_CLOSED) begin
                  state_in = ST_IDLE;
               end else if (req_item.op == OP_TIMEOUT) begin
                  if (phase_ff == PH_ESTAB && count_ff != '0) begin
                     state_in = ST_FETCH;
                  end else begin
                     state_in = ST_DECIDE;
                  end
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (match) begin
               hit_in   = 1'b1;
               state_in = ST_DECIDE;
            end else if (idx_ff >= count_ff) begin
               hit_in   = 1'b0;
               state_in = ST_DECIDE;
            end else begin
               idx_in  = idx_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
         end
         ST_FETCH: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (q_empty) begin
               state_in = ST_IDLE;
               if (item_ff.op == OP_TIMEOUT) begin
                  // timeout tick
                  if (phase_ff == PH_HANDSHAKE) begin
                     retry_in = retry_next;
                     if (retry_next >= max_retries) begin
                        r0        = make_reply(KIND_GIVEUP, '0, '0, '0, 1'b0, 1'b0);
                        push.push = 1'b1;
                        phase_in  = PH_CLOSED;
                     end
                  end else if (phase_ff == PH_ESTAB) begin
                     last_len_in = tail_len;
                     r0 = make_reply(KIND_ACK, tail_seq + SEQ_W'(tail_len),
                                     shrink_window(window_size, tail_len), tail_len,
                                     1'b0, 1'b0);
                     push.push = 1'b1;
                  end
               end else if (hit_ff) begin
                  // duplicate: re-acknowledge the stored entry
                  r0 = make_reply(KIND_ACK, rd_seq + SEQ_W'(rd_len), window_size, '0,
                                  1'b1, 1'b0);
                  push.push = 1'b1;
               end else begin
                  // new packet: record while there is room
                  if (count_ff < DEPTH_CNT) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
                  case (item_ff.ptype)
                     TYPE_SYN: begin
                        push.push = 1'b1;
                        phase_in  = PH_ESTAB;
                        if (retry_ff != '0) begin
                           retry_in = '0;
                           push.two = 1'b1;
                           r0 = make_reply(KIND_RST, seq_plus_one, window_size, '0,
                                           1'b0, 1'b0);
                           r1 = make_reply(KIND_ACK, seq_plus_one, window_size,
                                           last_len_ff, 1'b0, 1'b0);
                        end else begin
                           r0 = make_reply(KIND_ACK, seq_plus_one, window_size,
                                           last_len_ff, 1'b0, 1'b0);
                        end
                     end
                     TYPE_FIN: begin
                        push.push = 1'b1;
                        phase_in  = PH_CLOSED;
                        r0 = make_reply(KIND_ACK, seq_plus_one, window_size, last_len_ff,
                                        1'b0, 1'b1);
                     end
                     TYPE_RST: begin
                        push.push = 1'b1;
                        r0 = make_reply(KIND_ACK, seq_plus_one, window_size, '0,
                                        1'b0, 1'b0);
                     end
                     TYPE_DAT: begin
                        push.push   = 1'b1;
                        last_len_in = item_ff.len;
                        if (phase_ff == PH_ESTAB) begin
                           phase_in = PH_DATA;
                        end
                        r0 = make_reply(KIND_ACK, item_ff.seq + SEQ_W'(item_ff.len),
                                        shrink_window(window_size, item_ff.len),
                                        item_ff.len, 1'b0, 1'b0);
                     end
                     default: begin
                        // ack and unknown types are only recorded
                        push.push = 1'b0;
                     end
                  endcase
               end
               // mark the final reply of this item
               if (push.two) begin
                  r1.last = 1'b1;
               end else begin
                  r0.last = 1'b1;
               end
               push.first  = r0;
               push.second = r1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_HANDSHAKE;
         retry_ff    <= '0;
         last_len_ff <= '0;
         count_ff    <= '0;
         idx_ff      <= '0;
         pend_ff     <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         retry_ff    <= retry_in;
         last_len_ff <= last_len_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         pend_ff     <= pend_in;
         hit_ff      <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // checks
   `RDR_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_CNT,
      "seen table count beyond depth")
   `RDR_ASSERT_IMP(a_write_on_decide, clock, reset, wr_en, decide,
      "table written outside a decision")
   `RDR_ASSERT_IMP(a_read_in_range, clock, reset, rd_en, CNT_W'(rd_addr) < count_ff,
      "table read beyond stored entries")
   `RDR_ASSERT_NEXT(a_closed_ignores, clock, reset, accept && phase_ff == PH_CLOSED,
      state_ff == ST_IDLE && $stable(count_ff) && $stable(retry_ff),
      "item changed state after close")
   `RDR_ASSERT_IMP(a_last_marker, clock, reset, push.push && push.two,
      push.second.last && !push.first.last, "final reply marker misplaced")

endmodule

// ===== bench/tb_reliable_datagram_receiver.sv =====
// self-checking bench for the datagram receiver: queued packet and timeout items,
// a predictor of the reply items, random stalls on both streams and register phases
// depends on rdr_pkg and the reliable_datagram_receiver rtl
module tb_reliable_datagram_receiver;
   import rdr_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 6;
   localparam int IDLE_PCT      = 20;
   localparam int SETTLE_CYCLES = 100;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int LOG_DEPTH     = 64;
   localparam int MAX_REPORTS   = 10;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [79:0]          req_tdata  = '0;  // seq_num, payload_len, content_sig, zero pad
   logic [3:0]           req_tuser  = '0;  // operation, pkt_type
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;        // ack_num, adv_window, payload_echo, zero pad
   logic [3:0]           rsp_tuser;        // reply_kind, was_duplicate, released
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [WIN_W-1:0]     csr_wdata  = '0;

   reliable_datagram_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   // stimulus bookkeeping
   item_type  pending[$];
   item_type  sent_log[$];
   item_type  drv_item;
   logic      req_taken = 1'b0;
   logic      steady    = 1'b0;
   int        n_queued  = 0;
   int        n_taken   = 0;

   // predicted receiver state
   reply_type         replies_due[$];
   int                n_expected    = 0;
   int                n_checked     = 0;
   int                errors        = 0;
   logic [WIN_W-1:0]  window_cfg    = WINDOW_RESET;
   logic [RETRY_W-1:0] retries_cfg  = RETRIES_RESET;
   phase_type         conn_phase    = PH_HANDSHAKE;
   logic [RETRY_W-1:0] timeouts_seen = '0;
   logic [LEN_W-1:0]  last_len      = '0;
   logic [63:0]       log_key [LOG_DEPTH];
   logic [TYPE_W+LEN_W-1:0] log_meta [LOG_DEPTH];
   int                log_count     = 0;
   logic [SEQ_W-1:0]  next_seq      = 32'd4000;

   // window left after a payload, never below zero
   function automatic logic [WIN_W-1:0] window_after(input logic [LEN_W-1:0] len);
      logic [WIN_W:0] diff;
      diff = {1'b0, window_cfg} - (WIN_W+1)'(len);
      return diff[WIN_W] ? '0 : diff[WIN_W-1:0];
   endfunction

   function automatic reply_type reply_of(
      input logic [KIND_W-1:0] kind,
      input logic [SEQ_W-1:0]  ack,
      input logic [WIN_W-1:0]  win,
      input logic [LEN_W-1:0]  pay,
      input logic              dup,
      input logic              rel
   );
      reply_type r;
      r.kind = kind;
      r.ack  = ack;
      r.win  = win;
      r.pay  = pay;
      r.dup  = dup;
      r.rel  = rel;
      r.last = 1'b0;
      return r;
   endfunction

   // works out the replies of one accepted item and updates the connection state
   task automatic answer_item(input item_type it);
      logic [LEN_W-1:0]        len;
      logic [63:0]             key;
      logic [TYPE_W+LEN_W-1:0] meta;
      logic [SEQ_W-1:0]        s;
      logic [LEN_W-1:0]        l;
      reply_type               out [2];
      int                      n;
      int                      hit;
      n   = 0;
      hit = -1;
      len = (it.len > MAX_PAYLOAD) ? MAX_PAYLOAD : it.len;
      if (conn_phase == PH_CLOSED) begin
         n = 0;
      end else if (it.op == OP_TIMEOUT) begin
         if (conn_phase == PH_HANDSHAKE) begin
            timeouts_seen = timeouts_seen + 1'b1;
            if (timeouts_seen >= retries_cfg) begin
               out[n] = reply_of(KIND_GIVEUP, '0, '0, '0, 1'b0, 1'b0);
               n = n + 1;
               conn_phase = PH_CLOSED;
            end
         end else if (conn_phase == PH_ESTAB) begin
            // resend the ack of the newest logged packet
            s = '0;
            l = '0;
            if (log_count > 0) begin
               s = log_key[log_count-1][63:32];
               l = log_meta[log_count-1][LEN_W-1:0];
            end
            last_len = l;
            out[n] = reply_of(KIND_ACK, s + SEQ_W'(l), window_after(l), l, 1'b0, 1'b0);
            n = n + 1;
         end
      end else begin
         key  = {it.seq, it.sig};
         meta = {it.ptype, len};
         for (int i = 0; i < log_count; i++)
            if (hit < 0 && log_key[i] == key && log_meta[i] == meta) hit = i;
         if (hit >= 0) begin
            out[n] = reply_of(KIND_ACK, log_key[hit][63:32] + SEQ_W'(log_meta[hit][LEN_W-1:0]),
                              window_cfg, '0, 1'b1, 1'b0);
            n = n + 1;
         end else begin
            // a full log stops recording, the packet is still answered
            if (log_count < LOG_DEPTH) begin
               log_key[log_count]  = key;
               log_meta[log_count] = meta;
               log_count = log_count + 1;
            end
            case (it.ptype)
               TYPE_SYN: begin
                  if (timeouts_seen != 0) begin
                     out[n] = reply_of(KIND_RST, it.seq + 1, window_cfg, '0, 1'b0, 1'b0);
                     n = n + 1;
                     timeouts_seen = '0;
                  end
                  out[n] = reply_of(KIND_ACK, it.seq + 1, window_cfg, last_len, 1'b0, 1'b0);
                  n = n + 1;
                  conn_phase = PH_ESTAB;
               end
               TYPE_FIN: begin
                  out[n] = reply_of(KIND_ACK, it.seq + 1, window_cfg, last_len, 1'b0, 1'b1);
                  n = n + 1;
                  conn_phase = PH_CLOSED;
               end
               TYPE_RST: begin
                  out[n] = reply_of(KIND_ACK, it.seq + 1, window_cfg, '0, 1'b0, 1'b0);
                  n = n + 1;
               end
               TYPE_DAT: begin
                  if (conn_phase == PH_ESTAB) conn_phase = PH_DATA;
                  last_len = len;
                  out[n] = reply_of(KIND_ACK, it.seq + SEQ_W'(len), window_after(len), len,
                                    1'b0, 1'b0);
                  n = n + 1;
               end
               default: ;
            endcase
         end
      end
      for (int k = 0; k < n; k++) begin
         out[k].last = (k == n - 1);
         replies_due.push_back(out[k]);
         n_expected = n_expected + 1;
      end
   endtask

   // input driver, one item in flight on the bus
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            drv_item = pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {5'b0, drv_item.sig, drv_item.len, drv_item.seq};
            req_tuser  <= {drv_item.ptype, drv_item.op};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result stalls
   always @(negedge clock)
      rsp_tready <= !reset && (steady || $urandom_range(99) >= IDLE_PCT);

   // monitor: predict on accepted items, check accepted replies
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            answer_item(drv_item);
            req_taken = 1'b1;
            n_taken   = n_taken + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser[1:0];
            got.dup  = rsp_tuser[2];
            got.rel  = rsp_tuser[3];
            got.ack  = rsp_tdata[31:0];
            got.win  = rsp_tdata[47:32];
            got.pay  = rsp_tdata[58:48];
            got.last = rsp_tlast;
            if (replies_due.size() == 0) begin
               errors = errors + 1;
               if (errors <= MAX_REPORTS)
                  $display("unexpected reply: kind %0d ack %h win %0d pay %0d dup %b rel %b last %b",
                           got.kind, got.ack, got.win, got.pay, got.dup, got.rel, got.last);
            end else begin
               want = replies_due.pop_front();
               n_checked = n_checked + 1;
               if (got !== want) begin
                  errors = errors + 1;
                  if (errors <= MAX_REPORTS) begin
                     $display("reply mismatch at %0t", $realtime);
                     $display("  expected kind %0d ack %h win %0d pay %0d dup %b rel %b last %b",
                              want.kind, want.ack, want.win, want.pay, want.dup, want.rel,
                              want.last);
                     $display("  actual   kind %0d ack %h win %0d pay %0d dup %b rel %b last %b",
                              got.kind, got.ack, got.win, got.pay, got.dup, got.rel, got.last);
                  end
               end
            end
         end
      end
   end

   task automatic send(input item_type it);
      pending.push_back(it);
      n_queued = n_queued + 1;
      if (it.op == OP_PACKET) sent_log.push_back(it);
   endtask

   task automatic send_packet(
      input logic [TYPE_W-1:0] t,
      input logic [SEQ_W-1:0]  s,
      input logic [LEN_W-1:0]  l,
      input logic [SIG_W-1:0]  g
   );
      item_type it;
      it.op    = OP_PACKET;
      it.ptype = t;
      it.seq   = s;
      it.len   = l;
      it.sig   = g;
      send(it);
   endtask

   // timeout ticks carry random junk in the unused fields
   task automatic send_tick;
      item_type it;
      it.op    = OP_TIMEOUT;
      it.ptype = TYPE_W'($urandom);
      it.seq   = $urandom;
      it.len   = LEN_W'($urandom);
      it.sig   = $urandom;
      send(it);
   endtask

   // mostly well-formed traffic, with resends and some noise; never a fin
   task automatic send_random;
      int                 pick;
      int                 idx;
      logic [LEN_W-1:0]   l;
      logic [TYPE_W-1:0]  t;
      item_type           it;
      pick = $urandom_range(99);
      l = ($urandom_range(19) == 0) ? LEN_W'($urandom_range(2047, 1025))
                                    : LEN_W'($urandom_range(1024));
      if (pick < 40) begin
         send_packet(TYPE_DAT, next_seq, l, $urandom);
         next_seq = next_seq + SEQ_W'(l);
      end else if (pick < 60 && sent_log.size() != 0) begin
         // half of the resends hit the logged head of the history
         if ($urandom_range(1) == 0)
            idx = $urandom_range((sent_log.size() > LOG_DEPTH) ? LOG_DEPTH - 1
                                                                : sent_log.size() - 1);
         else
            idx = $urandom_range(sent_log.size() - 1);
         send(sent_log[idx]);
      end else if (pick < 68) begin
         send_packet(TYPE_SYN, next_seq, ($urandom_range(1) == 0) ? '0 : l, $urandom);
         next_seq = next_seq + 1;
      end else if (pick < 74) begin
         send_packet(TYPE_RST, $urandom, l, $urandom);
      end else if (pick < 80) begin
         send_packet(TYPE_ACK, $urandom, l, $urandom);
      end else if (pick < 84) begin
         send_packet(TYPE_W'($urandom_range(7, 5)), $urandom, l, $urandom);
      end else if (pick < 94) begin
         send_tick();
      end else begin
         t = TYPE_W'($urandom_range(6));
         if (t >= TYPE_FIN) t = t + 1'b1;
         it.op    = OP_PACKET;
         it.ptype = t;
         it.seq   = $urandom;
         it.len   = LEN_W'($urandom);
         it.sig   = $urandom;
         send(it);
      end
   endtask

   task automatic random_burst(input int count);
      repeat (count) send_random();
   endtask

   // sender holds off until every reply is back, then the block is left to finish
   task automatic drain_and_settle;
      wait (n_taken == n_queued && n_checked == n_expected);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_IDX_WINDOW)
         window_cfg = val;
      else
         retries_cfg = val[RETRY_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // handshake phase with the reset window, retries raised so ticks never give up
      write_csr(CSR_IDX_RETRIES, WIN_W'(15));
      send_packet(TYPE_DAT, 32'h0, 11'd0, 32'h0);
      send_packet(TYPE_DAT, 32'hFFFF_FFFF, 11'd1024, 32'hFFFF_FFFF);
      send_packet(TYPE_DAT, 32'd100, 11'd2047, 32'h1234_5678);
      send_packet(TYPE_DAT, 32'd100, 11'd2047, 32'h1234_5678);
      send_tick();
      send_tick();
      send_tick();
      send_packet(TYPE_RST, 32'hFFFF_FFFF, 11'd0, 32'hA5A5_A5A5);
      send_packet(TYPE_ACK, 32'd500, 11'd7, 32'h1);
      send_packet(3'd5, 32'h5555_5555, 11'd1, 32'h5);
      send_packet(3'd6, 32'hAAAA_AAAA, 11'd1500, 32'h6);
      send_packet(3'd7, 32'd7, 11'd1024, 32'h7);
      send_packet(TYPE_ACK, 32'd500, 11'd7, 32'h1);
      send_tick();
      send_tick();
      // syn after timeouts: rst then ack
      send_packet(TYPE_SYN, 32'd1000, 11'd3, 32'h2);
      send_tick();
      send_packet(TYPE_DAT, 32'd2000, 11'd1023, 32'h3);
      send_tick();
      send_packet(TYPE_SYN, 32'd3000, 11'd0, 32'h4);
      send_packet(TYPE_SYN, 32'd3000, 11'd0, 32'h4);
      send_tick();
      drain_and_settle();

      // zero window
      write_csr(CSR_IDX_WINDOW, '0);
      write_csr(CSR_IDX_RETRIES, WIN_W'(1));
      random_burst(420);
      drain_and_settle();

      // widest window, a long stretch with no stalls
      write_csr(CSR_IDX_WINDOW, 16'hFFFF);
      write_csr(CSR_IDX_RETRIES, '0);
      steady = 1'b1;
      random_burst(420);
      drain_and_settle();
      steady = 1'b0;

      write_csr(CSR_IDX_WINDOW, WIN_W'($urandom));
      write_csr(CSR_IDX_RETRIES, WIN_W'($urandom_range(15)));
      random_burst(200);
      drain_and_settle();
      random_burst(220);
      drain_and_settle();

      write_csr(CSR_IDX_WINDOW, WIN_W'(1024));
      write_csr(CSR_IDX_RETRIES, WIN_W'(8));
      random_burst(280);

      // fin closes the connection; later items are ignored
      send_packet(TYPE_FIN, next_seq, LEN_W'($urandom_range(1024)), $urandom);
      send_packet(TYPE_DAT, next_seq, 11'd10, $urandom);
      send_packet(TYPE_SYN, $urandom, 11'd0, $urandom);
      send_packet(TYPE_FIN, $urandom, 11'd0, $urandom);
      send_tick();
      drain_and_settle();

      if (errors == 0 && replies_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/rdr_pkg.sv
design/rdr_ram.sv
design/rdr_reply_q.sv
design/rdr_ctrl.sv
design/reliable_datagram_receiver.sv
bench/tb_reliable_datagram_receiver.sv
